FILE: rtl/bsah_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bsah_pkg: shared types and constants of the binned SAH split selector
// Coordinate and box types, fixed widths, status codes, divider handshake.
// ----------------------------------------------------------------------------
package bsah_pkg;

  localparam int CoordW     = 24;
  localparam int MaxBuckets = 16;
  localparam int BktW       = $clog2(MaxBuckets);
  localparam int NbW        = BktW + 1;
  localparam int MaxPrims   = 256;
  localparam int AddrW      = $clog2(MaxPrims);
  localparam int CntW       = AddrW + 1;
  localparam int AreaW      = 51;            // 2*(3 products of 24b) fits
  localparam int SumW       = AreaW - 1;
  localparam int WtW        = 60;            // area * count, plus one more
  localparam int DivW       = 51;            // divisor / remainder width
  localparam int QuoW       = 32;
  localparam int StepW      = 6;
  localparam int CostW      = 32;
  localparam int FracW      = 16;
  localparam int MulW       = 26;
  localparam int AreaLoW    = MulW;

  localparam logic signed [CoordW-1:0] CoordMax = {1'b0, {(CoordW-1){1'b1}}};
  localparam logic signed [CoordW-1:0] CoordMin = {1'b1, {(CoordW-1){1'b0}}};
  localparam logic [CostW-1:0] CostSat = '1;
  localparam logic [CostW-1:0] CostOne = CostW'(1) << FracW;

  typedef enum logic [1:0] {
    StSplit   = 2'd0,
    StNoSplit = 2'd1,
    StTooMany = 2'd2
  } split_status_e;

  typedef logic signed [CoordW-1:0] coord_t;

  typedef struct packed {
    coord_t [2:0] hi;
    coord_t [2:0] lo;
  } box_t;

  typedef struct packed {
    logic             start;
    logic [DivW-1:0]  rem;
    logic [QuoW-1:0]  num;
    logic [DivW-1:0]  den;
    logic [StepW-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic            busy;
    logic            done;
    logic [QuoW-1:0] quo;
  } div_rsp_t;

  function automatic box_t box_empty();
    box_t r;
    for (int a = 0; a < 3; a++) begin
      r.lo[a] = CoordMax;
      r.hi[a] = CoordMin;
    end
    return r;
  endfunction

  function automatic box_t box_merge(box_t d, box_t s);
    box_t r;
    r = d;
    for (int a = 0; a < 3; a++) begin
      if ($signed(s.lo[a]) < $signed(d.lo[a])) r.lo[a] = s.lo[a];
      if ($signed(s.hi[a]) > $signed(d.hi[a])) r.hi[a] = s.hi[a];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/binned_sah_split_selector.sv
`default_nettype none
// ----------------------------------------------------------------------------
// binned_sah_split_selector: binned SAH split search for one BVH node
// Collects primitives, bins centroids per axis, scores bucket boundaries.
// ----------------------------------------------------------------------------
// channel | dir | handshake               | beat
// cfg     | in  | cfg_valid_i/cfg_ready_o | bucket_count (5b)
// in      | in  | in_valid_i/in_ready_o   | centroid, box, last_item
// out     | out | out_valid_o/out_ready_i | status, axis, bucket, pos, cost
//
// Load: one primitive beat per cycle (one row write to each store).
// On last_item the node is evaluated: the node area, then per axis with
// positive extent a bucket index divide per primitive, prefix areas per
// bucket and a cost divide per scored boundary in the shared divider.
// The shared one-bit-per-cycle divider dominates. in_ready_o is low during
// evaluation; a waiting result only holds the next result, not the next
// load. No clearing pass after reset.
// ----------------------------------------------------------------------------
module binned_sah_split_selector import bsah_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [NbW-1:0]      cfg_bucket_count_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic signed [CoordW-1:0] centroid_x_i,
  input  logic signed [CoordW-1:0] centroid_y_i,
  input  logic signed [CoordW-1:0] centroid_z_i,
  input  logic signed [CoordW-1:0] box_min_x_i,
  input  logic signed [CoordW-1:0] box_min_y_i,
  input  logic signed [CoordW-1:0] box_min_z_i,
  input  logic signed [CoordW-1:0] box_max_x_i,
  input  logic signed [CoordW-1:0] box_max_y_i,
  input  logic signed [CoordW-1:0] box_max_z_i,
  input  logic                last_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [1:0]          split_status_o,
  output logic [1:0]          split_axis_o,
  output logic [BktW-1:0]     split_bucket_o,
  output logic signed [CoordW-1:0] split_position_o,
  output logic [CostW-1:0]    split_cost_o
);

  localparam int NumSt = 25;

  typedef enum logic [NumSt-1:0] {
    ST_LOAD  = NumSt'(1) << 0,
    ST_EV    = NumSt'(1) << 1,
    ST_AR0   = NumSt'(1) << 2,
    ST_AR1   = NumSt'(1) << 3,
    ST_AR2   = NumSt'(1) << 4,
    ST_AR3   = NumSt'(1) << 5,
    ST_DEN   = NumSt'(1) << 6,
    ST_AXS   = NumSt'(1) << 7,
    ST_BRD   = NumSt'(1) << 8,
    ST_BMUL  = NumSt'(1) << 9,
    ST_BDIV  = NumSt'(1) << 10,
    ST_BWAIT = NumSt'(1) << 11,
    ST_PSTEP = NumSt'(1) << 12,
    ST_W0    = NumSt'(1) << 13,
    ST_W1    = NumSt'(1) << 14,
    ST_W2    = NumSt'(1) << 15,
    ST_WEND  = NumSt'(1) << 16,
    ST_SSTEP = NumSt'(1) << 17,
    ST_SCHK  = NumSt'(1) << 18,
    ST_SDIV  = NumSt'(1) << 19,
    ST_SCMP  = NumSt'(1) << 20,
    ST_FIN   = NumSt'(1) << 21,
    ST_PDIV  = NumSt'(1) << 22,
    ST_PWAIT = NumSt'(1) << 23,
    ST_EMIT  = NumSt'(1) << 24
  } state_e;

  typedef enum logic [1:0] {
    PhDen = 2'd0,
    PhPre = 2'd1,
    PhSuf = 2'd2
  } phase_e;

  state_e          state_q;
  phase_e          phase_q;
  logic [NbW-1:0]  bc_q;
  logic [CntW-1:0] cnt_q, item_q, run_q;
  logic            ovf_q, found_q;
  box_t            cb_q, nbox_q, acc_q;
  logic [1:0]      axis_q, best_axis_q;
  logic [BktW-1:0] b_q, best_bucket_q;
  coord_t          cmin_q;
  logic [CoordW-1:0] ext_q;
  logic [AreaW-1:0]  denom_q;
  logic [SumW-1:0]   ar_sum_q;
  logic [WtW-1:0]    wt_q, w_q;
  logic [CostW-1:0]  cost_q, best_cost_q;
  split_status_e     res_status_q, out_status_q;
  coord_t            res_pos_q, out_pos_q;
  logic              out_valid_q;
  logic [1:0]        out_axis_q;
  logic [BktW-1:0]   out_bucket_q;
  logic [CostW-1:0]  out_cost_q;
  logic [2*MulW-1:0] mul_q;

  box_t            bkt_box_q [MaxBuckets];
  logic [CntW-1:0] bkt_cnt_q [MaxBuckets];
  logic [CntW-1:0] lcnt_q    [MaxBuckets];
  logic [WtW-1:0]  lw_q      [MaxBuckets];

  // comb
  logic              in_fire, emit_go;
  logic [NbW-1:0]    nb, nb_m1;
  logic [CoordW-1:0] dd [3];
  logic [AreaW-1:0]  area;
  logic [1:0]        axis_ix;
  logic signed [CoordW:0] ext_s, ext_bs;
  logic              ext_pos;
  coord_t            cent;
  logic [CoordW-1:0] off;
  logic [BktW-1:0]   bm1, bkt_sel, bin_idx;
  box_t              bkt_rd, acc_mg, in_box, cent_box;
  logic [CntW-1:0]   bkt_cnt_rd, run_next;
  logic              sat, better;
  logic [CostW-1:0]  cost_new;
  logic [MulW-1:0]   mul_a, mul_b;
  div_req_t          div_req;
  div_rsp_t          div_rsp;
  coord_t [2:0]      cent_wr, cent_rd;
  box_t              box_rd;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_LOAD);
  assign in_fire     = in_valid_i && in_ready_o;
  assign emit_go     = (state_q == ST_EMIT) && (!out_valid_q || out_ready_i);

  // bucket count in use, clamped to [2, MaxBuckets]
  assign nb    = (bc_q < NbW'(2)) ? NbW'(2) :
                 (bc_q > NbW'(MaxBuckets)) ? NbW'(MaxBuckets) : bc_q;
  assign nb_m1 = nb - NbW'(1);

  assign cent_wr  = {centroid_z_i, centroid_y_i, centroid_x_i};
  assign cent_box = '{hi: cent_wr, lo: cent_wr};
  assign in_box   = '{hi: {box_max_z_i, box_max_y_i, box_max_x_i},
                      lo: {box_min_z_i, box_min_y_i, box_min_x_i}};

  // extents of the working box, negative ones count as zero
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      dd[a] = ($signed(acc_q.hi[a]) > $signed(acc_q.lo[a])) ?
              CoordW'(acc_q.hi[a] - acc_q.lo[a]) : '0;
    end
  end
  assign area = {ar_sum_q, 1'b0};

  assign axis_ix = (axis_q == 2'd3) ? 2'd0 : axis_q;
  assign ext_s   = {cb_q.hi[axis_ix][CoordW-1], cb_q.hi[axis_ix]} -
                   {cb_q.lo[axis_ix][CoordW-1], cb_q.lo[axis_ix]};
  assign ext_pos = !ext_s[CoordW] && (ext_s != '0);
  assign ext_bs  = {cb_q.hi[best_axis_q][CoordW-1], cb_q.hi[best_axis_q]} -
                   {cb_q.lo[best_axis_q][CoordW-1], cb_q.lo[best_axis_q]};

  assign cent = cent_rd[axis_ix];
  assign off  = ($signed(cent) > $signed(cmin_q)) ? CoordW'(cent - cmin_q) : '0;

  assign bin_idx = (div_rsp.quo[NbW-1:0] > nb_m1) ? nb_m1[BktW-1:0] :
                   div_rsp.quo[BktW-1:0];
  assign bm1     = b_q - BktW'(1);
  assign bkt_sel = (state_q == ST_BWAIT) ? bin_idx : b_q;
  assign bkt_rd     = bkt_box_q[bkt_sel];
  assign bkt_cnt_rd = bkt_cnt_q[bkt_sel];
  assign run_next   = run_q + bkt_cnt_rd;
  assign acc_mg     = (bkt_cnt_rd != '0) ? box_merge(acc_q, bkt_rd) : acc_q;

  // quotient at or above 1.0 * 2^16 saturates before the divider runs
  assign sat      = (DivW+FracW)'(w_q) >= {denom_q, {FracW{1'b0}}};
  assign cost_new = (div_rsp.quo[QuoW-1:FracW] == '1) ? CostSat :
                    div_rsp.quo + CostOne;
  // ties: earlier axis kept; within an axis the lower bucket, seen later
  assign better = !found_q || (cost_q < best_cost_q) ||
                  ((cost_q == best_cost_q) && (best_axis_q == axis_q));

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_AR0: begin mul_a = MulW'(dd[0]); mul_b = MulW'(dd[1]); end
      ST_AR1: begin mul_a = MulW'(dd[1]); mul_b = MulW'(dd[2]); end
      ST_AR2: begin mul_a = MulW'(dd[2]); mul_b = MulW'(dd[0]); end
      ST_W0:  begin mul_a = MulW'(area[AreaW-1:AreaLoW]); mul_b = MulW'(run_q); end
      ST_W1:  begin mul_a = MulW'(area[AreaLoW-1:0]);     mul_b = MulW'(run_q); end
      ST_BMUL: begin mul_a = MulW'(off); mul_b = MulW'(nb); end
      ST_FIN: begin
        mul_a = MulW'(ext_bs[CoordW-1:0]);
        mul_b = MulW'({1'b0, best_bucket_q} + NbW'(1));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    mul_q <= mul_a * mul_b;
  end

  // shared divider requests
  always_comb begin
    div_req = '0;
    case (state_q)
      ST_BDIV: begin
        div_req.start = 1'b1;
        div_req.rem   = DivW'(mul_q[CoordW+NbW-1:NbW]);
        div_req.num   = {mul_q[NbW-1:0], {(QuoW-NbW){1'b0}}};
        div_req.den   = DivW'(ext_q);
        div_req.steps = StepW'(NbW);
      end
      ST_SCHK: begin
        div_req.start = !sat;
        div_req.rem   = DivW'(w_q[WtW-1:FracW]);
        div_req.num   = {w_q[FracW-1:0], {(QuoW-FracW){1'b0}}};
        div_req.den   = denom_q;
        div_req.steps = StepW'(QuoW);
      end
      ST_PDIV: begin
        div_req.start = 1'b1;
        div_req.rem   = '0;
        div_req.num   = {mul_q[CoordW+NbW-1:0], {(QuoW-CoordW-NbW){1'b0}}};
        div_req.den   = DivW'(nb);
        div_req.steps = StepW'(CoordW+NbW);
      end
      default: ;
    endcase
  end

  bsah_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  bsah_ram #(.Width($bits(cent_wr)), .Depth(MaxPrims)) u_cent_ram (
    .clk_i   (clk_i),
    .we_i    (in_fire && (cnt_q != CntW'(MaxPrims))),
    .waddr_i (cnt_q[AddrW-1:0]),
    .wdata_i (cent_wr),
    .re_i    (state_q == ST_BRD),
    .raddr_i (item_q[AddrW-1:0]),
    .rdata_o (cent_rd)
  );

  bsah_ram #(.Width($bits(box_t)), .Depth(MaxPrims)) u_box_ram (
    .clk_i   (clk_i),
    .we_i    (in_fire && (cnt_q != CntW'(MaxPrims))),
    .waddr_i (cnt_q[AddrW-1:0]),
    .wdata_i (in_box),
    .re_i    (state_q == ST_BRD),
    .raddr_i (item_q[AddrW-1:0]),
    .rdata_o (box_rd)
  );

  // sequencer and control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_LOAD;
      phase_q       <= PhDen;
      bc_q          <= NbW'(12);
      cnt_q         <= '0;
      item_q        <= '0;
      run_q         <= '0;
      ovf_q         <= 1'b0;
      found_q       <= 1'b0;
      cb_q          <= box_empty();
      nbox_q        <= box_empty();
      axis_q        <= '0;
      b_q           <= '0;
      best_axis_q   <= '0;
      best_bucket_q <= '0;
      best_cost_q   <= CostSat;
      res_status_q  <= StNoSplit;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        bc_q <= cfg_bucket_count_i;
      end
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_LOAD: begin
          if (in_fire) begin
            if (cnt_q == CntW'(MaxPrims)) begin
              ovf_q <= 1'b1;
            end else begin
              cnt_q  <= cnt_q + CntW'(1);
              cb_q   <= box_merge(cb_q, cent_box);
              nbox_q <= box_merge(nbox_q, in_box);
            end
            if (last_item_i) state_q <= ST_EV;
          end
        end
        ST_EV: begin
          found_q     <= 1'b0;
          best_cost_q <= CostSat;
          if (ovf_q) begin
            res_status_q <= StTooMany;
            state_q      <= ST_EMIT;
          end else if (cnt_q < CntW'(2)) begin
            res_status_q <= StNoSplit;
            state_q      <= ST_EMIT;
          end else begin
            phase_q <= PhDen;
            state_q <= ST_AR0;
          end
        end
        ST_AR0: state_q <= ST_AR1;
        ST_AR1: state_q <= ST_AR2;
        ST_AR2: state_q <= ST_AR3;
        ST_AR3: state_q <= (phase_q == PhDen) ? ST_DEN : ST_W0;
        ST_DEN: begin
          axis_q  <= '0;
          state_q <= ST_AXS;
        end
        ST_AXS: begin
          if (axis_q == 2'd3) begin
            state_q <= ST_FIN;
          end else if (!ext_pos) begin
            axis_q <= axis_q + 2'd1;
          end else begin
            item_q  <= '0;
            state_q <= ST_BRD;
          end
        end
        ST_BRD: begin
          if (item_q == cnt_q) begin
            run_q   <= '0;
            b_q     <= '0;
            state_q <= ST_PSTEP;
          end else begin
            state_q <= ST_BMUL;
          end
        end
        ST_BMUL: state_q <= ST_BDIV;
        ST_BDIV: state_q <= ST_BWAIT;
        ST_BWAIT: begin
          if (div_rsp.done) begin
            item_q  <= item_q + CntW'(1);
            state_q <= ST_BRD;
          end
        end
        ST_PSTEP: begin
          if ({1'b0, b_q} == nb_m1) begin
            run_q   <= '0;
            b_q     <= nb_m1[BktW-1:0];
            state_q <= ST_SSTEP;
          end else begin
            run_q <= run_next;
            if (run_next == '0) begin
              b_q <= b_q + BktW'(1);
            end else begin
              phase_q <= PhPre;
              state_q <= ST_AR0;
            end
          end
        end
        ST_W0: state_q <= ST_W1;
        ST_W1: state_q <= ST_W2;
        ST_W2: state_q <= ST_WEND;
        ST_WEND: begin
          if (phase_q == PhPre) begin
            b_q     <= b_q + BktW'(1);
            state_q <= ST_PSTEP;
          end else begin
            state_q <= ST_SCHK;
          end
        end
        ST_SSTEP: begin
          if (b_q == '0) begin
            axis_q  <= axis_q + 2'd1;
            state_q <= ST_AXS;
          end else begin
            run_q <= run_next;
            if ((lcnt_q[bm1] != '0) && (run_next != '0)) begin
              phase_q <= PhSuf;
              state_q <= ST_AR0;
            end else begin
              b_q <= bm1;
            end
          end
        end
        ST_SCHK: state_q <= sat ? ST_SCMP : ST_SDIV;
        ST_SDIV: if (div_rsp.done) state_q <= ST_SCMP;
        ST_SCMP: begin
          if (better) begin
            found_q       <= 1'b1;
            best_cost_q   <= cost_q;
            best_axis_q   <= axis_q;
            best_bucket_q <= bm1;
          end
          b_q     <= bm1;
          state_q <= ST_SSTEP;
        end
        ST_FIN: begin
          if (!found_q) begin
            res_status_q <= StNoSplit;
            state_q      <= ST_EMIT;
          end else begin
            state_q <= ST_PDIV;
          end
        end
        ST_PDIV: state_q <= ST_PWAIT;
        ST_PWAIT: begin
          if (div_rsp.done) begin
            res_status_q <= StSplit;
            state_q      <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (emit_go) begin
            out_valid_q <= 1'b1;
            cnt_q       <= '0;
            ovf_q       <= 1'b0;
            cb_q        <= box_empty();
            nbox_q      <= box_empty();
            state_q     <= ST_LOAD;
          end
        end
        default: state_q <= ST_LOAD;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_EV:  acc_q <= nbox_q;
      ST_AR1: ar_sum_q <= SumW'(mul_q);
      ST_AR2: ar_sum_q <= ar_sum_q + SumW'(mul_q);
      ST_AR3: ar_sum_q <= ar_sum_q + SumW'(mul_q);
      ST_DEN: denom_q <= (area == '0) ? AreaW'(1) : area;
      ST_AXS: begin
        cmin_q <= cb_q.lo[axis_ix];
        ext_q  <= ext_s[CoordW-1:0];
        for (int k = 0; k < MaxBuckets; k++) begin
          bkt_box_q[k] <= box_empty();
          bkt_cnt_q[k] <= '0;
        end
      end
      ST_BRD: acc_q <= box_empty();
      ST_BWAIT: begin
        if (div_rsp.done) begin
          bkt_box_q[bin_idx] <= box_merge(bkt_box_q[bin_idx], box_rd);
          bkt_cnt_q[bin_idx] <= bkt_cnt_q[bin_idx] + CntW'(1);
        end
      end
      ST_PSTEP: begin
        if ({1'b0, b_q} == nb_m1) begin
          acc_q <= box_empty();
        end else begin
          acc_q       <= acc_mg;
          lcnt_q[b_q] <= run_next;
        end
      end
      ST_W1: wt_q <= {mul_q[WtW-AreaLoW-1:0], {AreaLoW{1'b0}}};
      ST_W2: wt_q <= wt_q + WtW'(mul_q);
      ST_WEND: begin
        if (phase_q == PhPre) lw_q[b_q] <= wt_q;
        else                  w_q <= lw_q[bm1] + wt_q;
      end
      ST_SSTEP: if (b_q != '0) acc_q <= acc_mg;
      ST_SCHK: if (sat) cost_q <= CostSat;
      ST_SDIV: if (div_rsp.done) cost_q <= cost_new;
      ST_FIN: cmin_q <= cb_q.lo[best_axis_q];
      ST_PWAIT: begin
        if (div_rsp.done) res_pos_q <= cmin_q + coord_t'(div_rsp.quo[CoordW-1:0]);
      end
      ST_EMIT: begin
        if (emit_go) begin
          out_status_q <= res_status_q;
          if (res_status_q == StSplit) begin
            out_axis_q   <= best_axis_q;
            out_bucket_q <= best_bucket_q;
            out_pos_q    <= res_pos_q;
            out_cost_q   <= best_cost_q;
          end else begin
            out_axis_q   <= '0;
            out_bucket_q <= '0;
            out_pos_q    <= '0;
            out_cost_q   <= '0;
          end
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o      = out_valid_q;
  assign split_status_o   = out_status_q;
  assign split_axis_o     = out_axis_q;
  assign split_bucket_o   = out_bucket_q;
  assign split_position_o = out_pos_q;
  assign split_cost_o     = out_cost_q;

`ifndef NO_ASSERTIONS
  a_load_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !div_rsp.busy)
    else $error("divider busy while loading");
  a_nosplit_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (split_status_o != StSplit)) |->
      (split_cost_o == '0) && (split_position_o == '0) && (split_axis_o == '0))
    else $error("non-split result carries fields");
  a_cost_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (split_status_o == StSplit)) |-> (split_cost_o >= CostOne))
    else $error("split cost below one");
  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MaxPrims))
    else $error("item count past capacity");
`endif

endmodule
`default_nettype wire

FILE: rtl/bsah_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bsah_ram: generic single-write, single-read RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module bsah_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

FILE: rtl/bsah_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bsah_div: shared restoring divider, one quotient bit per cycle
// Remainder starts at req.rem (< den); req.num bits shift in MSB first.
// ----------------------------------------------------------------------------
module bsah_div import bsah_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic             busy_q, done_q;
  logic [StepW-1:0] cnt_q;
  logic [DivW-1:0]  rem_q, den_q;
  logic [QuoW-1:0]  num_q, quo_q;
  logic [DivW:0]    shifted;
  logic             ge;
  logic [DivW-1:0]  rem_n;

  always_comb begin
    shifted = {rem_q, num_q[QuoW-1]};
    ge      = shifted >= {1'b0, den_q};
    rem_n   = ge ? DivW'(shifted - {1'b0, den_q}) : shifted[DivW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.steps;
      end else if (busy_q) begin
        cnt_q <= cnt_q - StepW'(1);
        if (cnt_q == StepW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= req_i.rem;
      num_q <= req_i.num;
      den_q <= req_i.den;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= rem_n;
      num_q <= {num_q[QuoW-2:0], 1'b0};
      quo_q <= {quo_q[QuoW-2:0], ge};
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

`ifndef NO_ASSERTIONS
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q) && !busy_q)
    else $error("divider done without a run");
`endif

endmodule
`default_nettype wire

FILE: tb/tb_binned_sah_split_selector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_binned_sah_split_selector: self-checking bench for the SAH split selector
// Streams node primitives through the valid/ready ports, predicts each
// node's split from its own model of the binning and scoring, and checks
// every result beat field by field under several idle/stall mixes.
// ----------------------------------------------------------------------------
module tb_binned_sah_split_selector;
  import bsah_pkg::*;

  typedef struct {
    coord_t [2:0] cen;
    coord_t [2:0] lo;
    coord_t [2:0] hi;
    logic         last;
  } prim_t;

  typedef struct {
    logic [1:0]        status;
    logic [1:0]        axis;
    logic [BktW-1:0]   bucket;
    logic [CoordW-1:0] pos;
    logic [CostW-1:0]  cost;
  } split_t;

  localparam longint CMaxL = 64'sd8388607;
  localparam longint CMinL = -64'sd8388608;
  localparam longint unsigned UMax = 64'hFFFF_FFFF_FFFF_FFFF;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [NbW-1:0] cfg_bucket_count_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  coord_t centroid_x_i = '0, centroid_y_i = '0, centroid_z_i = '0;
  coord_t box_min_x_i = '0, box_min_y_i = '0, box_min_z_i = '0;
  coord_t box_max_x_i = '0, box_max_y_i = '0, box_max_z_i = '0;
  logic last_item_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [1:0] split_status_o, split_axis_o;
  logic [BktW-1:0] split_bucket_o;
  coord_t split_position_o;
  logic [CostW-1:0] split_cost_o;

  binned_sah_split_selector dut (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_bucket_count_i,
    .in_valid_i, .in_ready_o, .centroid_x_i, .centroid_y_i, .centroid_z_i,
    .box_min_x_i, .box_min_y_i, .box_min_z_i, .box_max_x_i, .box_max_y_i,
    .box_max_z_i, .last_item_i, .out_valid_o, .out_ready_i, .split_status_o,
    .split_axis_o, .split_bucket_o, .split_position_o, .split_cost_o
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Run-wide knobs: percent of cycles the sender idles / receiver stalls.
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned mismatches = 0;
  split_t pending_splits[$];

  // ---------------------------------------------------------------- predictor
  // Node state mirrored from the block: stored primitives, centroid bounds,
  // node box, item count, overflow and the bucket count register.
  longint cen_mem[MaxPrims*3];
  longint box_mem[MaxPrims*6];
  int unsigned node_items;
  bit node_ovf;
  longint cen_bnd[6];
  longint node_bx[6];
  logic [NbW-1:0] buckets_reg = 5'd12;

  function automatic void box_clear(output longint b[6]);
    for (int a = 0; a < 3; a++) begin
      b[a] = CMaxL;
      b[a+3] = CMinL;
    end
  endfunction

  function automatic void box_grow(inout longint d[6], input longint s[6]);
    for (int a = 0; a < 3; a++) begin
      if (s[a] < d[a]) d[a] = s[a];
      if (s[a+3] > d[a+3]) d[a+3] = s[a+3];
    end
  endfunction

  function automatic longint unsigned sadd(longint unsigned a, longint unsigned b);
    return (a > UMax - b) ? UMax : a + b;
  endfunction

  function automatic longint unsigned smul(longint unsigned a, longint unsigned b);
    if (b != 0 && a > UMax / b) return UMax;
    return a * b;
  endfunction

  function automatic longint unsigned surface(longint b[6]);
    longint unsigned d[3];
    longint unsigned s;
    for (int a = 0; a < 3; a++) d[a] = (b[a+3] > b[a]) ? longint'(b[a+3] - b[a]) : 0;
    s = sadd(smul(d[0], d[1]), smul(d[1], d[2]));
    s = sadd(s, smul(d[2], d[0]));
    return smul(s, 2);
  endfunction

  // 1 + weighted/denom in 16.16, saturating; restoring long division for the
  // fraction bits
  function automatic longint unsigned sah_cost(longint unsigned al, longint unsigned lc,
      longint unsigned ar, longint unsigned rc, longint unsigned den);
    longint unsigned w, q, r, frac;
    bit top;
    w = sadd(smul(al, lc), smul(ar, rc));
    q = w / den;
    r = w % den;
    frac = 0;
    if (q >= 64'hFFFF) return 64'hFFFF_FFFF;
    for (int i = 0; i < 16; i++) begin
      top = r[63];
      r = r << 1;
      frac = frac << 1;
      if (top || r >= den) begin
        r = r - den;
        frac = frac | 1;
      end
    end
    return ((q + 1) << 16) | frac;
  endfunction

  function automatic void node_reset();
    node_items = 0;
    node_ovf = 0;
    box_clear(cen_bnd);
    box_clear(node_bx);
  endfunction

  function automatic split_t choose_split();
    split_t res;
    bit found;
    longint unsigned best_cost, best_axis, best_bkt, nb, den, off, idx, cost, ext_u;
    longint cmin, ext, pos;
    longint bk_box[MaxBuckets][6];
    int unsigned bk_cnt[MaxBuckets];
    longint lft_box[MaxBuckets][6], rgt_box[MaxBuckets][6];
    int unsigned lft_cnt[MaxBuckets], rgt_cnt[MaxBuckets];
    longint acc[6], one[6];
    int unsigned n;
    res = '{default: '0};
    found = 0;
    best_cost = 0; best_axis = 0; best_bkt = 0;
    if (node_ovf) begin
      res.status = StTooMany;
      return res;
    end
    if (node_items < 2) begin
      res.status = StNoSplit;
      return res;
    end
    nb = buckets_reg;
    if (nb < 2) nb = 2;
    if (nb > MaxBuckets) nb = MaxBuckets;
    den = surface(node_bx);
    if (den == 0) den = 1;
    for (int ax = 0; ax < 3; ax++) begin
      cmin = cen_bnd[ax];
      ext = cen_bnd[ax+3] - cmin;
      if (ext <= 0) continue;
      for (int b = 0; b < nb; b++) begin
        box_clear(bk_box[b]);
        bk_cnt[b] = 0;
      end
      for (int i = 0; i < node_items; i++) begin
        off = (cen_mem[i*3+ax] > cmin) ? longint'(cen_mem[i*3+ax] - cmin) : 0;
        idx = off * nb / longint'(ext);
        if (idx > nb - 1) idx = nb - 1;
        for (int k = 0; k < 6; k++) one[k] = box_mem[i*6+k];
        box_grow(bk_box[idx], one);
        bk_cnt[idx]++;
      end
      box_clear(acc);
      n = 0;
      for (int b = 0; b < nb; b++) begin
        if (bk_cnt[b] != 0) box_grow(acc, bk_box[b]);
        n += bk_cnt[b];
        lft_box[b] = acc;
        lft_cnt[b] = n;
      end
      box_clear(acc);
      n = 0;
      for (int b = int'(nb) - 1; b >= 0; b--) begin
        if (bk_cnt[b] != 0) box_grow(acc, bk_box[b]);
        n += bk_cnt[b];
        rgt_box[b] = acc;
        rgt_cnt[b] = n;
      end
      for (int b = 0; b + 1 < nb; b++) begin
        if (lft_cnt[b] == 0 || rgt_cnt[b+1] == 0) continue;
        cost = sah_cost(surface(lft_box[b]), lft_cnt[b], surface(rgt_box[b+1]),
                        rgt_cnt[b+1], den);
        if (!found || cost < best_cost) begin
          found = 1;
          best_cost = cost;
          best_axis = ax;
          best_bkt = b;
        end
      end
    end
    if (!found) begin
      res.status = StNoSplit;
      return res;
    end
    cmin = cen_bnd[best_axis];
    ext_u = longint'(cen_bnd[best_axis+3] - cmin);
    pos = cmin + longint'(ext_u * (best_bkt + 1) / nb);
    res.status = StSplit;
    res.axis = best_axis[1:0];
    res.bucket = best_bkt[BktW-1:0];
    res.pos = pos[CoordW-1:0];
    res.cost = best_cost[CostW-1:0];
    return res;
  endfunction

  // Absorb one accepted primitive; queue a result when it closes the node.
  function automatic void absorb_prim(prim_t p);
    longint bx[6];
    if (node_items >= MaxPrims) begin
      node_ovf = 1;
    end else begin
      for (int a = 0; a < 3; a++) begin
        cen_mem[node_items*3+a] = p.cen[a];
        if (p.cen[a] < cen_bnd[a]) cen_bnd[a] = p.cen[a];
        if (p.cen[a] > cen_bnd[a+3]) cen_bnd[a+3] = p.cen[a];
        bx[a] = p.lo[a];
        bx[a+3] = p.hi[a];
      end
      for (int k = 0; k < 6; k++) box_mem[node_items*6+k] = bx[k];
      box_grow(node_bx, bx);
      node_items++;
    end
    if (p.last) begin
      pending_splits.push_back(choose_split());
      node_reset();
    end
  endfunction

  // ------------------------------------------------------------------ checker
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    split_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_splits.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("%0t: result beat with nothing expected", $realtime);
      end else begin
        e = pending_splits.pop_front();
        if (split_status_o !== e.status || split_axis_o !== e.axis ||
            split_bucket_o !== e.bucket || split_position_o !== e.pos ||
            split_cost_o !== e.cost) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: split mismatch exp st=%0d ax=%0d bk=%0d pos=%h cost=%h got st=%0d ax=%0d bk=%0d pos=%h cost=%h",
                     $realtime, e.status, e.axis, e.bucket, e.pos, e.cost,
                     split_status_o, split_axis_o, split_bucket_o,
                     split_position_o, split_cost_o);
        end
      end
    end
  end

  // ------------------------------------------------------------------- driver
  task automatic send_prim(prim_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    {centroid_x_i, centroid_y_i, centroid_z_i} <= {p.cen[0], p.cen[1], p.cen[2]};
    {box_min_x_i, box_min_y_i, box_min_z_i} <= {p.lo[0], p.lo[1], p.lo[2]};
    {box_max_x_i, box_max_y_i, box_max_z_i} <= {p.hi[0], p.hi[1], p.hi[2]};
    last_item_i <= p.last;
    do @(posedge clk_i); while (!in_ready_o);
    absorb_prim(p);
  endtask

  // Sender pause: hold off until every queued split has come back.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_splits.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_buckets(logic [NbW-1:0] v);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_bucket_count_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    buckets_reg = v;
  endtask

  function automatic prim_t make_prim(coord_t c0, coord_t c1, coord_t c2, int half,
                                      logic last);
    prim_t p;
    p.cen = {c2, c1, c0};
    for (int a = 0; a < 3; a++) begin
      p.lo[a] = p.cen[a] - coord_t'(half);
      p.hi[a] = p.cen[a] + coord_t'(half);
    end
    p.last = last;
    return p;
  endfunction

  // Random primitive: mostly clustered near a node base, sometimes full range,
  // occasionally with an inverted or degenerate box.
  function automatic prim_t rand_prim(coord_t base, int spread, logic last);
    prim_t p;
    int sel;
    sel = $urandom_range(15);
    for (int a = 0; a < 3; a++) begin
      if (sel == 0) begin
        p.cen[a] = coord_t'($urandom);
        p.lo[a] = coord_t'($urandom);
        p.hi[a] = coord_t'($urandom);
      end else begin
        p.cen[a] = base + coord_t'($urandom_range(spread));
        p.lo[a] = p.cen[a] - coord_t'($urandom_range(spread / 4 + 1));
        p.hi[a] = p.cen[a] + coord_t'($urandom_range(spread / 4 + 1));
        if (sel == 1) {p.lo[a], p.hi[a]} = {p.hi[a], p.lo[a]};
        if (sel == 2) p.hi[a] = p.lo[a];
      end
    end
    p.last = last;
    return p;
  endfunction

  // ------------------------------------------------------------------- tests
  task automatic test_directed();
    prim_t p;
    // lone primitive: no split, with the most positive corner
    send_prim(make_prim(CoordMax, CoordMax, CoordMax, 0, 1'b1));
    // two primitives at opposite extremes of the coordinate range
    p.cen = {CoordMin, CoordMin, CoordMin};
    p.lo = {CoordMin, CoordMin, CoordMin};
    p.hi = {CoordMax, CoordMax, CoordMax};
    p.last = 1'b0;
    send_prim(p);
    p.cen = {CoordMax, CoordMax, CoordMax};
    p.last = 1'b1;
    send_prim(p);
    // identical centroids: no axis has extent
    repeat (3) send_prim(make_prim(24'sd100, -24'sd50, 24'sd7, 64, 1'b0));
    send_prim(make_prim(24'sd100, -24'sd50, 24'sd7, 64, 1'b1));
    // point boxes: zero node area, cost is exactly one
    send_prim(make_prim(24'sd0, 24'sd0, 24'sd0, 0, 1'b0));
    send_prim(make_prim(24'sd0, 24'sd0, 24'sd0, 0, 1'b0));
    send_prim(make_prim(24'sd256, 24'sd0, 24'sd0, 0, 1'b1));
    // inverted box merged as given
    p = make_prim(24'sd10, 24'sd20, 24'sd30, 16, 1'b0);
    p.lo = p.hi;
    p.hi = make_prim(24'sd10, 24'sd20, 24'sd30, -16, 1'b0).hi;
    send_prim(p);
    send_prim(make_prim(24'sd900, 24'sd20, 24'sd30, 16, 1'b1));
    // symmetric layout on all three axes: ties go to x and the lower bucket
    send_prim(make_prim(-24'sd512, -24'sd512, -24'sd512, 32, 1'b0));
    send_prim(make_prim(24'sd0, 24'sd0, 24'sd0, 32, 1'b0));
    send_prim(make_prim(24'sd512, 24'sd512, 24'sd512, 32, 1'b1));
    // one huge box dominating: large weighted area, the best cost is two
    send_prim(make_prim(24'sd0, 24'sd0, 24'sd0, 4000000, 1'b0));
    send_prim(make_prim(24'sd1, 24'sd1, 24'sd1, 0, 1'b0));
    send_prim(make_prim(24'sd2, 24'sd2, 24'sd2, 0, 1'b1));
    drain();
  endtask

  task automatic test_node_overflow();
    // full node, then one past the limit
    for (int i = 0; i < MaxPrims; i++)
      send_prim(rand_prim(coord_t'(-1000), 2000, i == MaxPrims - 1));
    for (int i = 0; i <= MaxPrims; i++)
      send_prim(rand_prim(coord_t'(5000), 300, i == MaxPrims));
    drain();
  endtask

  task automatic test_random_nodes(int unsigned items);
    int unsigned sent, size;
    coord_t base;
    int spread;
    sent = 0;
    while (sent < items) begin
      size = ($urandom_range(7) == 0) ? $urandom_range(1, 40) : $urandom_range(2, 10);
      base = coord_t'($urandom);
      base = base >>> $urandom_range(12);
      spread = 1 << $urandom_range(4, 20);
      for (int i = 0; i < size; i++) send_prim(rand_prim(base, spread, i == size - 1));
      sent += size;
      // sender pause until the block has caught up
      if ($urandom_range(9) == 0) drain();
    end
  endtask

  task automatic set_pressure(int unsigned idle, int unsigned stall);
    send_idle_pct = idle;
    recv_stall_pct = stall;
  endtask

  // -------------------------------------------------------------------- main
  initial begin
    node_reset();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();                    // reset bucket count of 12
    write_buckets(5'd2);
    test_directed();
    write_buckets(5'd16);
    test_directed();
    test_node_overflow();
    write_buckets(5'd0);                // below range acts as 2
    test_random_nodes(60);
    write_buckets(5'd31);               // above range acts as 16
    test_random_nodes(60);

    set_pressure(0, 0);
    write_buckets(5'($urandom_range(2, 16)));
    test_random_nodes(200);
    set_pressure(64, 0);
    write_buckets(5'($urandom_range(31)));
    test_random_nodes(200);
    set_pressure(0, 64);
    write_buckets(5'($urandom_range(2, 16)));
    test_random_nodes(200);
    set_pressure(30, 30);
    write_buckets(5'd1);
    test_random_nodes(200);
    write_buckets(5'($urandom_range(31)));
    test_random_nodes(200);

    drain();
    repeat (50) @(posedge clk_i);
    if (mismatches == 0 && pending_splits.size() == 0) begin
      $display("binned_sah_split_selector verification clean");
    end else begin
      $display("binned_sah_split_selector verification failed");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("binned_sah_split_selector verification failed");
    $finish;
  end

endmodule
